// ===== design/dfq_pkg.sv =====
package dfq_pkg;

  localparam int DFQ_CAPACITY   = 1024;
  localparam int DFQ_ITEM_WIDTH = 32;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int PEEK_W  = 10;
  localparam int COUNT_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } fsm_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  item_value;
    logic [PEEK_W-1:0]   peek_index;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  item_count;
  } result_t;

endpackage

// ===== design/dedup_fifo_queue_core.sv =====
// Duplicate-rejecting FIFO over a single-port-read ring memory. Raise start with
// a request while busy is low; exactly one result follows on result, marked by a
// one-cycle done strobe that cannot be held off. An enqueue into a queue holding
// N entries reads the stored entries once each through the memory read port,
// stopping early when a duplicate is found, and its result follows the end of
// the scan. A dequeue or an in-range peek takes one memory read.
// Every other request (enqueue into an empty queue, dequeue from an empty queue,
// out-of-range peek, unused kind) completes in the accept cycle and reports on
// the next. A new request may be accepted in the same cycle that done is shown.
module dedup_fifo_queue_core
  import dfq_pkg::*;
#(
  parameter int CAPACITY   = DFQ_CAPACITY,
  parameter int ITEM_WIDTH = DFQ_ITEM_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     done,
  output result_t  result
);

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PEEK_W) ? CW : PEEK_W;

  fsm_t                  state, state_next;
  logic [PW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  kind_t                 op_kind, op_kind_next;
  logic [ITEM_WIDTH-1:0] op_value, op_value_next;
  logic [CW-1:0]         scan_idx, scan_idx_next;
  logic                  pend, pend_next;
  logic                  done_next;
  result_t               result_next;

  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [PW-1:0]         mem_raddr;
  logic [ITEM_WIDTH-1:0] rdata;

  logic accept;
  logic in_range;
  logic hit;
  logic last;

  function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] base,
                                              input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PW+1)'(CAPACITY)) begin
      sum = sum - (PW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  dfq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = CMPW'(item.peek_index) < CMPW'(count);
  assign hit      = pend && (rdata == op_value);
  assign last     = pend && (scan_idx == count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_ENQ:  if (count != '0) state_next = S_SCAN;
            KIND_DEQ:  if (count != '0) state_next = S_READ;
            KIND_PEEK: if (in_range) state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || last) state_next = S_IDLE;
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    head_next     = head;
    count_next    = count;
    op_kind_next  = op_kind;
    op_value_next = op_value;
    scan_idx_next = scan_idx;
    pend_next     = pend;
    done_next     = 1'b0;
    result_next   = result;
    mem_we        = 1'b0;
    mem_waddr     = ring_slot(head, PW'(count));
    mem_wdata     = op_value;
    mem_raddr     = head;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_kind_next  = item.kind;
          op_value_next = ITEM_WIDTH'(item.item_value);
          scan_idx_next = '0;
          pend_next     = 1'b0;
          unique case (item.kind)
            KIND_ENQ: begin
              if (count == '0) begin
                mem_we                 = 1'b1;
                mem_wdata              = ITEM_WIDTH'(item.item_value);
                count_next             = count + CW'(1);
                done_next              = 1'b1;
                result_next.status     = ST_OK;
                result_next.value_out  = '0;
                result_next.item_count = COUNT_W'(count + CW'(1));
              end
            end
            KIND_DEQ: begin
              if (count == '0) begin
                done_next              = 1'b1;
                result_next.status     = ST_EMPTY;
                result_next.value_out  = '0;
                result_next.item_count = COUNT_W'(count);
              end
            end
            KIND_PEEK: begin
              if (in_range) begin
                mem_raddr = ring_slot(head, PW'(item.peek_index));
              end else begin
                done_next              = 1'b1;
                result_next.status     = ST_EMPTY;
                result_next.value_out  = '0;
                result_next.item_count = COUNT_W'(count);
              end
            end
            default: begin
              done_next              = 1'b1;
              result_next.status     = ST_OK;
              result_next.value_out  = '0;
              result_next.item_count = COUNT_W'(count);
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_idx < count) begin
          mem_raddr     = ring_slot(head, PW'(scan_idx));
          scan_idx_next = scan_idx + CW'(1);
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        priority if (hit) begin
          done_next              = 1'b1;
          result_next.status     = ST_DUP;
          result_next.value_out  = '0;
          result_next.item_count = COUNT_W'(count);
        end else if (last) begin
          done_next             = 1'b1;
          result_next.value_out = '0;
          if (count >= CW'(CAPACITY)) begin
            result_next.status     = ST_FULL;
            result_next.item_count = COUNT_W'(count);
          end else begin
            mem_we                 = 1'b1;
            count_next             = count + CW'(1);
            result_next.status     = ST_OK;
            result_next.item_count = COUNT_W'(count + CW'(1));
          end
        end else begin
          done_next = 1'b0;
        end
      end
      S_READ: begin
        done_next             = 1'b1;
        result_next.status    = ST_OK;
        result_next.value_out = VALUE_W'(rdata);
        if (op_kind == KIND_DEQ) begin
          head_next              = ring_slot(head, PW'(1));
          count_next             = count - CW'(1);
          result_next.item_count = COUNT_W'(count - CW'(1));
        end else begin
          result_next.item_count = COUNT_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind  <= op_kind_next;
    op_value <= op_value_next;
    scan_idx <= scan_idx_next;
    result   <= result_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> done && (state == S_IDLE))
    else $error("memory read did not complete the transaction");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.kind == KIND_DEQ) && (count == '0)) |=>
      done && (result.status == ST_EMPTY))
    else $error("dequeue from empty queue not reported");

  a_count_out: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.item_count == COUNT_W'(count)))
    else $error("reported count differs from occupancy");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.value_out == '0))
    else $error("rejected transaction carries a value");

endmodule

// ===== design/dfq_ram.sv =====
module dfq_ram
  import dfq_pkg::*;
#(
  parameter int DEPTH = DFQ_CAPACITY,
  parameter int WIDTH = DFQ_ITEM_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
